// ===== rtl/core/threshold_monitor_with_suppression_assert.svh =====
// Assertion macros for the threshold monitor.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef THRESHOLD_MONITOR_WITH_SUPPRESSION_ASSERT_SVH
`define THRESHOLD_MONITOR_WITH_SUPPRESSION_ASSERT_SVH

`ifndef SYNTH

// Consequence must hold in the same cycle.
`define TMS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tms assertion failed");

// Consequence must hold in the next cycle.
`define TMS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tms assertion failed");

`else

`define TMS_ASSERT_SAME(name, clk, rst, ante, cons)
`define TMS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/tms_pkg.sv =====
`timescale 1ns / 1ps

package tms_pkg;

   localparam int NUM_COUNTED   = 5;
   localparam int NUM_SLOTS     = 6;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int HOLD_BITS     = 16;

   // Channel codes
   localparam logic [2:0] CH_RTT        = 3'd0;
   localparam logic [2:0] CH_LOSS       = 3'd1;
   localparam logic [2:0] CH_CPU        = 3'd2;
   localparam logic [2:0] CH_GPU        = 3'd3;
   localparam logic [2:0] CH_FRAME_DROP = 3'd4;
   localparam logic [2:0] CH_ENC_LAG    = 3'd5;
   localparam logic [2:0] CH_RENDER_LAG = 3'd6;

   // Alert sources
   localparam logic [1:0] SRC_NETWORK = 2'd0;
   localparam logic [1:0] SRC_SYSTEM  = 2'd1;
   localparam logic [1:0] SRC_ENCODER = 2'd2;

   // Alert levels
   localparam logic LVL_WARNING  = 1'b0;
   localparam logic LVL_CRITICAL = 1'b1;

   // Register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_HOLD_COUNT = 3'd5;

   // Fixed lag limits, Q16.16 milliseconds
   localparam logic [31:0] ENC_LAG_LIMIT    = 32'h0032_0000;
   localparam logic [31:0] RENDER_LAG_LIMIT = 32'h001E_0000;

   localparam int unsigned SUPPRESS_SECONDS = 300;

   typedef struct packed {
      logic [2:0]  channel;
      logic [31:0] reading;
      logic [31:0] frame_total;
      logic [31:0] now_seconds;
      logic        end_of_sample;
   } req_type;

   typedef struct packed {
      logic        alert_level;
      logic [1:0]  alert_source;
      logic [2:0]  alert_channel;
      logic [31:0] alert_value;
      logic [31:0] alert_time;
   } rsp_type;

   typedef struct packed {
      logic [NUM_COUNTED-1:0][63:0] limits;
      logic [HOLD_BITS-1:0]         hold_count;
   } cfg_type;

   // Limit check outcome; counted clear with over_warn set marks a lag warning.
   typedef struct packed {
      logic counted;
      logic over_crit;
      logic over_warn;
   } check_type;

   typedef struct packed {
      logic s2_load;
      logic s3_load;
   } pipe_ctl_type;

   function automatic logic [1:0] source_of(input logic [2:0] ch);
      logic [1:0] src;
      if (ch <= CH_LOSS) begin
         src = SRC_NETWORK;
      end else if (ch <= CH_GPU) begin
         src = SRC_SYSTEM;
      end else begin
         src = SRC_ENCODER;
      end
      return src;
   endfunction

endpackage

// ===== rtl/core/threshold_monitor_with_suppression.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_payload (channel reading, time, end mark)
// rsp       out        rsp_valid/rsp_ready  rsp_payload (alert level, source, value, time)
// csr       in/out     psel/penable/pready  paddr, pwdata, prdata (64-bit registers)
//
// One request per cycle while no stage is stalled; the accepting edge loads the input
// register, and an alerting request then passes the product, check and result registers.
// The frame drop products take their own stage; the state update in the last stage
// sets the per-cycle limit (counter, suppression and clear checks).
// Reset clears the limits, hold count, counters, last clear time and the raise-seen flags.
// A stalled result holds the last stage only while it holds an alert; others retire meanwhile.

`include "threshold_monitor_with_suppression_assert.svh"

module threshold_monitor_with_suppression #(
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tms_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tms_pkg::rsp_type                   rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tms_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [tms_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [tms_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   tms_pkg::cfg_type      cfg;
   tms_pkg::pipe_ctl_type ctl;
   tms_pkg::req_type      s1_req_ff;
   tms_pkg::req_type      s3_req;
   tms_pkg::check_type    s3_chk;
   tms_pkg::rsp_type      alert_rsp;
   tms_pkg::rsp_type      rsp_payload_ff;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take, out_free, alert_fire;
   logic s1_go, s2_go, s3_go;
   logic s1_free, s2_free, s3_free;

   // Configuration registers
   tms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Pipeline advance: each stage moves when the one after it is empty or moving.
   // The last stage retires freely unless it raises an alert into a full result register.
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign s3_go     = s3_valid_ff & (~alert_fire | out_free);
   assign s3_free   = ~s3_valid_ff | s3_go;
   assign s2_go     = s2_valid_ff & s3_free;
   assign s2_free   = ~s2_valid_ff | s2_go;
   assign s1_go     = s1_valid_ff & s2_free;
   assign s1_free   = ~s1_valid_ff | s1_go;
   assign req_ready = s1_free;
   assign req_take  = req_valid & req_ready;

   assign ctl.s2_load = s1_go;
   assign ctl.s3_load = s2_go;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~s1_go);
   assign s2_valid_in  = s1_go | (s2_valid_ff & ~s2_go);
   assign s3_valid_in  = s2_go | (s3_valid_ff & ~s3_go);
   // hold the result until taken, load a new alert when stage three retires one
   assign rsp_valid_in = (s3_go & alert_fire) | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_payload;
      end
   end

   // Drop-ratio products, then limit compares
   tms_limit_check u_limit_check (
      .clock  (clock),
      .ctl    (ctl),
      .s1_req (s1_req_ff),
      .cfg    (cfg),
      .s3_req (s3_req),
      .s3_chk (s3_chk)
   );

   // Violation counters, suppression history and periodic clear
   tms_alert_state #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_alert_state (
      .clock      (clock),
      .reset      (reset),
      .valid      (s3_valid_ff),
      .commit     (s3_go),
      .req        (s3_req),
      .chk        (s3_chk),
      .hold_count (cfg.hold_count),
      .fire       (alert_fire),
      .rsp        (alert_rsp)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (s3_go && alert_fire) begin
         rsp_payload_ff <= alert_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A waiting result is never overwritten by a new alert.
   `TMS_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !(s3_go && alert_fire))
   // An alert retired from the last stage shows up as a result.
   `TMS_ASSERT_NEXT(a_alert_delivered, clock, reset, s3_go && alert_fire, rsp_valid_ff)
   // An accepted request always lands in the input register.
   `TMS_ASSERT_NEXT(a_req_captured, clock, reset, req_valid && req_ready, s1_valid_ff)
   // No alert without an item in the last stage.
   `TMS_ASSERT_SAME(a_fire_needs_item, clock, reset, !s3_valid_ff, !alert_fire)

endmodule

// ===== rtl/core/tms_csr.sv =====
`timescale 1ns / 1ps

module tms_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tms_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [tms_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [tms_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready,
   output tms_pkg::cfg_type                      cfg
);

   tms_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr_en;

   assign idx    = paddr[5:3];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         priority if (idx < 3'(tms_pkg::NUM_COUNTED)) begin
            cfg_in.limits[idx] = pwdata;
         end else if (idx == tms_pkg::REG_HOLD_COUNT) begin
            cfg_in.hold_count = pwdata[tms_pkg::HOLD_BITS-1:0];
         end
      end
   end

   always_comb begin
      priority if (idx < 3'(tms_pkg::NUM_COUNTED)) begin
         prdata = cfg_ff.limits[idx];
      end else if (idx == tms_pkg::REG_HOLD_COUNT) begin
         prdata = tms_pkg::CSR_DATA_BITS'(cfg_ff.hold_count);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/tms_limit_check.sv =====
`timescale 1ns / 1ps

module tms_limit_check (
   input  logic                  clock,
   input  tms_pkg::pipe_ctl_type ctl,
   input  tms_pkg::req_type      s1_req,
   input  tms_pkg::cfg_type      cfg,
   output tms_pkg::req_type      s3_req,
   output tms_pkg::check_type    s3_chk
);

   tms_pkg::req_type   s2_req_ff;
   logic [63:0]        crit_prod_ff, warn_prod_ff;
   logic [63:0]        crit_prod_in, warn_prod_in;
   tms_pkg::req_type   s3_req_ff;
   tms_pkg::check_type s3_chk_ff, chk_in;
   logic [63:0]        lim;
   logic [63:0]        drop_lhs;

   // Drop ratio: dropped / total > limit becomes dropped * 2^16 > limit * total.
   assign crit_prod_in = 64'(cfg.limits[tms_pkg::CH_FRAME_DROP][63:32]) *
                         64'(s1_req.frame_total);
   assign warn_prod_in = 64'(cfg.limits[tms_pkg::CH_FRAME_DROP][31:0]) *
                         64'(s1_req.frame_total);

   always_ff @(posedge clock) begin
      if (ctl.s2_load) begin
         s2_req_ff    <= s1_req;
         crit_prod_ff <= crit_prod_in;
         warn_prod_ff <= warn_prod_in;
      end
   end

   assign drop_lhs = {16'h0000, s2_req_ff.reading, 16'h0000};
   assign lim      = (s2_req_ff.channel < 3'(tms_pkg::NUM_COUNTED)) ?
                     cfg.limits[s2_req_ff.channel] : '0;

   always_comb begin
      chk_in = '0;
      unique case (s2_req_ff.channel)
         tms_pkg::CH_RTT, tms_pkg::CH_LOSS, tms_pkg::CH_CPU, tms_pkg::CH_GPU: begin
            chk_in.counted   = 1'b1;
            chk_in.over_crit = s2_req_ff.reading > lim[63:32];
            chk_in.over_warn = s2_req_ff.reading > lim[31:0];
         end
         tms_pkg::CH_FRAME_DROP: begin
            // zero total: skip the channel entirely
            if (s2_req_ff.frame_total != '0) begin
               chk_in.counted   = 1'b1;
               chk_in.over_crit = drop_lhs > crit_prod_ff;
               chk_in.over_warn = drop_lhs > warn_prod_ff;
            end
         end
         tms_pkg::CH_ENC_LAG: begin
            chk_in.over_warn = s2_req_ff.reading > tms_pkg::ENC_LAG_LIMIT;
         end
         tms_pkg::CH_RENDER_LAG: begin
            chk_in.over_warn = s2_req_ff.reading > tms_pkg::RENDER_LAG_LIMIT;
         end
         default: begin
            chk_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.s3_load) begin
         s3_req_ff <= s2_req_ff;
         s3_chk_ff <= chk_in;
      end
   end

   assign s3_req = s3_req_ff;
   assign s3_chk = s3_chk_ff;

endmodule

// ===== rtl/core/tms_alert_state.sv =====
`timescale 1ns / 1ps

module tms_alert_state #(
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            valid,
   input  logic                            commit,
   input  tms_pkg::req_type                req,
   input  tms_pkg::check_type              chk,
   input  logic [tms_pkg::HOLD_BITS-1:0]   hold_count,
   output logic                            fire,
   output tms_pkg::rsp_type                rsp
);

   localparam int CMP_BITS = (COUNT_BITS > tms_pkg::HOLD_BITS) ?
                             COUNT_BITS : tms_pkg::HOLD_BITS;

   logic [tms_pkg::NUM_COUNTED-1:0][COUNT_BITS-1:0] count_ff, count_in;
   logic [TIME_BITS-1:0]                           clear_time_ff, clear_time_in;
   logic [tms_pkg::NUM_SLOTS-1:0][TIME_BITS-1:0]   raise_time_ff, raise_time_in;
   logic [tms_pkg::NUM_SLOTS-1:0]                  seen_ff, seen_in;

   logic [TIME_BITS-1:0]  now, since_raise, since_clear;
   logic [2:0]            cnt_idx;
   logic [COUNT_BITS-1:0] cnt_cur, cnt_next;
   logic                  violation, hold_met, want, level, suppressed, clear_due;
   logic [1:0]            src;
   logic [2:0]            slot;

   assign now     = TIME_BITS'(req.now_seconds);
   assign cnt_idx = chk.counted ? req.channel : tms_pkg::CH_RTT;
   assign cnt_cur = count_ff[cnt_idx];
   // saturate at all ones
   assign cnt_next = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

   assign violation = chk.counted & (chk.over_crit | chk.over_warn);
   assign hold_met  = CMP_BITS'(cnt_next) >= CMP_BITS'(hold_count);
   assign want      = (violation & hold_met) | (~chk.counted & chk.over_warn);
   assign level     = chk.counted & chk.over_crit;
   assign src       = tms_pkg::source_of(req.channel);
   assign slot      = {src, level};

   assign since_raise = now - raise_time_ff[slot];
   assign suppressed  = seen_ff[slot] &
                        (since_raise < TIME_BITS'(tms_pkg::SUPPRESS_SECONDS));
   assign fire        = valid & want & ~suppressed;

   assign since_clear = now - clear_time_ff;
   assign clear_due   = req.end_of_sample & (since_clear > TIME_BITS'(hold_count));

   always_comb begin
      count_in      = count_ff;
      clear_time_in = clear_time_ff;
      seen_in       = seen_ff;
      raise_time_in = raise_time_ff;
      if (commit && chk.counted) begin
         count_in[cnt_idx] = violation ? cnt_next : '0;
      end
      if (commit && fire) begin
         seen_in[slot]       = 1'b1;
         raise_time_in[slot] = now;
      end
      // periodic clear runs after this reading's update
      if (commit && clear_due) begin
         count_in      = '0;
         clear_time_in = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         clear_time_ff <= '0;
         seen_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         clear_time_ff <= clear_time_in;
         seen_ff       <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      raise_time_ff <= raise_time_in;
   end

   always_comb begin
      rsp.alert_level   = level;
      rsp.alert_source  = src;
      rsp.alert_channel = req.channel;
      rsp.alert_value   = req.reading;
      rsp.alert_time    = req.now_seconds;
   end

endmodule

// ===== dv/tb_threshold_monitor_with_suppression.sv =====
`timescale 1ns / 1ps

module tb_threshold_monitor_with_suppression;
   import tms_pkg::*;

   localparam int PERIOD_NS    = 4;
   localparam int RESET_CYCLES = 9;
   // Drain allowance for the path from the input register to the result register.
   localparam int DRAIN_CYCLES = 8;
   localparam int SETTLE_LIMIT = 20000;
   localparam int TIMEOUT_NS   = 4000000;
   localparam int PHASE_ITEMS  = 100;

   // Limit register indexes follow the channel codes.
   localparam int REG_RTT_LIMITS  = 0;
   localparam int REG_LOSS_LIMITS = 1;
   localparam int REG_CPU_LIMITS  = 2;
   localparam int REG_GPU_LIMITS  = 3;
   localparam int REG_DROP_LIMITS = 4;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_type;

   // One row of the directed plan: either a register setting or a request, the
   // latter optionally with a hand-written expected alert.
   typedef struct {
      bit      is_setting;
      cfg_type setting;
      req_type req;
      bit      typed;
      bit      typed_hit;
      rsp_type typed_alert;
   } plan_row;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_payload;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // Predictor copy of the configuration and the monitor state.
   cfg_type                model_cfg;
   logic [HOLD_BITS-1:0]   viol_count [NUM_COUNTED];
   logic [31:0]            clear_time;
   logic [31:0]            raise_time [NUM_SLOTS];
   bit                     raised     [NUM_SLOTS];

   rsp_type     pending_alerts [$];
   plan_row     plan [$];
   int          mismatch_count = 0;
   idle_type    pace = IDLE_NONE;
   int          stall_request = 0;
   int          stall_left = 0;
   logic [31:0] sim_seconds = 32'd10000;

   threshold_monitor_with_suppression dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Alert predictor
   // ------------------------------------------------------------------

   function automatic logic [1:0] alert_source_for(input logic [2:0] ch);
      case (ch)
         CH_RTT, CH_LOSS: return SRC_NETWORK;
         CH_CPU, CH_GPU:  return SRC_SYSTEM;
         default:         return SRC_ENCODER;
      endcase
   endfunction

   // Raise unless the same source and level fired less than the window ago.
   // A suppressed alert leaves the raise time untouched.
   function automatic bit raise_unless_recent(input logic level, input req_type r,
                                              output rsp_type a);
      logic [1:0]  src;
      int          slot;
      logic [31:0] since;
      src   = alert_source_for(r.channel);
      slot  = int'(src) * 2 + int'(level);
      since = r.now_seconds - raise_time[slot];
      a     = '0;
      if (raised[slot] && since < SUPPRESS_SECONDS) begin
         return 1'b0;
      end
      raised[slot]     = 1'b1;
      raise_time[slot] = r.now_seconds;
      a = rsp_type'{level, src, r.channel, r.reading, r.now_seconds};
      return 1'b1;
   endfunction

   function automatic bit predict_alert(input req_type r, output rsp_type a);
      logic [31:0] warn;
      logic [31:0] crit;
      logic [63:0] scaled_drop;
      logic [31:0] elapsed;
      bit          over_crit;
      bit          over_warn;
      bit          active;
      bit          hit;
      int          i;
      hit = 1'b0;
      a   = '0;
      if (r.channel < NUM_COUNTED) begin
         warn   = model_cfg.limits[r.channel][31:0];
         crit   = model_cfg.limits[r.channel][63:32];
         active = 1'b1;
         if (r.channel == CH_FRAME_DROP) begin
            // Ratio test by cross multiplication; a zero total skips the channel.
            scaled_drop = {16'd0, r.reading, 16'd0};
            if (r.frame_total == 32'd0) begin
               active    = 1'b0;
               over_crit = 1'b0;
               over_warn = 1'b0;
            end else begin
               over_crit = scaled_drop > ({32'd0, crit} * {32'd0, r.frame_total});
               over_warn = scaled_drop > ({32'd0, warn} * {32'd0, r.frame_total});
            end
         end else begin
            over_crit = r.reading > crit;
            over_warn = r.reading > warn;
         end
         if (active) begin
            if (over_crit || over_warn) begin
               if (viol_count[r.channel] != '1) begin
                  viol_count[r.channel] = viol_count[r.channel] + 1'b1;
               end
               if (viol_count[r.channel] >= model_cfg.hold_count) begin
                  hit = raise_unless_recent(over_crit ? LVL_CRITICAL : LVL_WARNING, r, a);
               end
            end else begin
               viol_count[r.channel] = '0;
            end
         end
      end else if (r.channel == CH_ENC_LAG) begin
         if (r.reading > ENC_LAG_LIMIT) begin
            hit = raise_unless_recent(LVL_WARNING, r, a);
         end
      end else if (r.channel == CH_RENDER_LAG) begin
         if (r.reading > RENDER_LAG_LIMIT) begin
            hit = raise_unless_recent(LVL_WARNING, r, a);
         end
      end
      elapsed = r.now_seconds - clear_time;
      if (r.end_of_sample && elapsed > {16'd0, model_cfg.hold_count}) begin
         for (i = 0; i < NUM_COUNTED; i++) begin
            viol_count[i] = '0;
         end
         clear_time = r.now_seconds;
      end
      return hit;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic bit sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      case (pace)
         IDLE_SENDER: return roll < 79;
         IDLE_BOTH:   return roll < 24;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_ready();
      int roll;
      roll = $urandom_range(0, 99);
      case (pace)
         IDLE_RECEIVER: return roll >= 79;
         IDLE_BOTH:     return roll >= 24;
         default:       return 1'b1;
      endcase
   endfunction

   // Readings cluster around the configured limits; time mostly creeps forward,
   // sometimes jumps past the suppression window, rarely lands anywhere.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         sim_seconds = sim_seconds + $urandom_range(0, 3);
      end else if (pick < 90) begin
         sim_seconds = sim_seconds + $urandom_range(50, 400);
      end else if (pick < 97) begin
         sim_seconds = sim_seconds + $urandom_range(1000, 100000);
      end else begin
         sim_seconds = $urandom();
      end
      r.now_seconds   = sim_seconds;
      r.channel       = ($urandom_range(0, 49) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      r.end_of_sample = ($urandom_range(0, 3) == 0);
      r.frame_total   = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 120);
      pick = $urandom_range(0, 99);
      if (r.channel == CH_FRAME_DROP) begin
         r.reading = (pick < 85) ? $urandom_range(0, 30) : $urandom();
      end else if (pick < 10) begin
         r.reading = $urandom();
      end else if (pick < 13) begin
         r.reading = '1;
      end else if (pick < 16) begin
         r.reading = '0;
      end else begin
         r.reading = ($urandom_range(0, 260) << 16) | $urandom_range(0, 65535);
      end
      return r;
   endfunction

   // Limits near typical readings, a quarter of them crossed (critical below warning).
   function automatic cfg_type random_setting();
      cfg_type     s;
      logic [31:0] warn;
      logic [31:0] crit;
      int          i;
      for (i = 0; i < NUM_COUNTED; i++) begin
         warn = (i == CH_FRAME_DROP) ? $urandom_range(1024, 24576)
                                     : ($urandom_range(20, 150) << 16);
         if ($urandom_range(0, 3) == 0) begin
            crit = warn - (warn >> 2);
         end else begin
            crit = warn + (warn >> 1);
         end
         s.limits[i] = {crit, warn};
      end
      s.hold_count = $urandom_range(0, 4);
      return s;
   endfunction

   function automatic void plan_setting(input cfg_type s);
      plan_row row;
      row.is_setting  = 1'b1;
      row.setting     = s;
      row.req         = '0;
      row.typed       = 1'b0;
      row.typed_hit   = 1'b0;
      row.typed_alert = '0;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_request(input req_type r, input bit typed, input bit hit,
                                        input rsp_type a);
      plan_row row;
      row.is_setting  = 1'b0;
      row.setting     = '0;
      row.req         = r;
      row.typed       = typed;
      row.typed_hit   = hit;
      row.typed_alert = a;
      plan.insert(plan.size(), row);
   endfunction

   task automatic show_mismatch(input string what, input logic [63:0] expected,
                                input logic [63:0] actual);
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, expected, actual);
      mismatch_count++;
   endtask

   // Offer one request; the prediction is taken at the edge that accepts it.
   // A typed expectation, where given, replaces the predicted one.
   task automatic send_req(input req_type r, input bit typed, input bit typed_hit,
                           input rsp_type typed_alert);
      bit      hit;
      rsp_type a;
      @(negedge clock);
      while (sender_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      hit = predict_alert(r, a);
      if (typed) begin
         hit = typed_hit;
         a   = typed_alert;
      end
      if (hit) begin
         pending_alerts.insert(pending_alerts.size(), a);
      end
   endtask

   // Drop valid, wait for every expected alert, then let the pipeline empty.
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_alerts.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_alerts.size() != 0) begin
         $display("%0t ns: %0d expected alerts never arrived", $time, pending_alerts.size());
         mismatch_count++;
         pending_alerts.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, then read it back.
   task automatic write_register(input int index, input logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] seen;
      mask = (index == int'(REG_HOLD_COUNT)) ? 64'h0000_0000_0000_FFFF : '1;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(index * 8);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      if (index < NUM_COUNTED) begin
         model_cfg.limits[index] = value;
      end else begin
         model_cfg.hold_count = value[HOLD_BITS-1:0];
      end
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      seen = prdata;
      if ((seen & mask) !== (value & mask)) begin
         show_mismatch("register read", value & mask, seen & mask);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_setting(input cfg_type s);
      int i;
      settle();
      for (i = 0; i < NUM_COUNTED; i++) begin
         write_register(i, s.limits[i]);
      end
      write_register(int'(REG_HOLD_COUNT), {48'd0, s.hold_count});
   endtask

   task automatic run_phase(input idle_type mode, input int count, input cfg_type s);
      apply_setting(s);
      pace = mode;
      repeat (count) send_req(random_request(), 1'b0, 1'b0, '0);
   endtask

   // ------------------------------------------------------------------
   // Result side: ready pacing with an optional long hold-off
   // ------------------------------------------------------------------

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= receiver_ready();
         end
      end
   end

   // Compare every accepted alert against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_payload;
         if (pending_alerts.size() == 0) begin
            $display("%0t ns: unexpected alert, expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = pending_alerts.pop_front();
            if (got.alert_level !== want.alert_level) begin
               show_mismatch("alert_level", want.alert_level, got.alert_level);
            end
            if (got.alert_source !== want.alert_source) begin
               show_mismatch("alert_source", want.alert_source, got.alert_source);
            end
            if (got.alert_channel !== want.alert_channel) begin
               show_mismatch("alert_channel", want.alert_channel, got.alert_channel);
            end
            if (got.alert_value !== want.alert_value) begin
               show_mismatch("alert_value", want.alert_value, got.alert_value);
            end
            if (got.alert_time !== want.alert_time) begin
               show_mismatch("alert_time", want.alert_time, got.alert_time);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      cfg_type setting_b;
      cfg_type all_zero;
      cfg_type all_ones;
      req_type r;
      int      i;

      // Hold every input at a known value; model state matches reset.
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      model_cfg   = '0;
      clear_time  = '0;
      for (i = 0; i < NUM_COUNTED; i++) begin
         viol_count[i] = '0;
      end
      for (i = 0; i < NUM_SLOTS; i++) begin
         raise_time[i] = '0;
         raised[i]     = 1'b0;
      end

      all_zero = '0;
      all_ones = '0;
      for (i = 0; i < NUM_COUNTED; i++) begin
         all_ones.limits[i] = '1;
      end

      setting_b                            = '0;
      setting_b.limits[REG_RTT_LIMITS]  = {32'h00C8_0000, 32'h0064_0000};
      setting_b.limits[REG_LOSS_LIMITS] = '1;
      // Crossed: critical 10 below warning 80.
      setting_b.limits[REG_CPU_LIMITS]  = {32'h000A_0000, 32'h0050_0000};
      setting_b.limits[REG_GPU_LIMITS]  = {32'h005A_0000, 32'h0046_0000};
      setting_b.limits[REG_DROP_LIMITS] = {32'h0000_1999, 32'h0000_0CCC};
      setting_b.hold_count                 = 16'd2;

      // Reset values: zero limits and zero hold, so any nonzero reading is critical.
      plan_request(req_type'{CH_RTT, 32'd0, 32'd0, 32'd1000, 1'b0}, 1, 0, '0);
      plan_request(req_type'{CH_RTT, 32'd1, 32'd0, 32'd1000, 1'b0}, 1, 1,
                   rsp_type'{LVL_CRITICAL, SRC_NETWORK, CH_RTT, 32'd1, 32'd1000});
      // Same source and level at the same second: suppressed.
      plan_request(req_type'{CH_LOSS, '1, 32'd0, 32'd1000, 1'b0}, 1, 0, '0);
      plan_request(req_type'{CH_CPU, '1, 32'd0, 32'd1001, 1'b0}, 1, 1,
                   rsp_type'{LVL_CRITICAL, SRC_SYSTEM, CH_CPU, '1, 32'd1001});
      // Zero frame total skips the drop channel.
      plan_request(req_type'{CH_FRAME_DROP, 32'd5, 32'd0, 32'd1002, 1'b0}, 1, 0, '0);
      plan_request(req_type'{CH_FRAME_DROP, 32'd1, 32'd1, 32'd1003, 1'b0}, 1, 1,
                   rsp_type'{LVL_CRITICAL, SRC_ENCODER, CH_FRAME_DROP, 32'd1, 32'd1003});
      // Lag exactly at its limit stays quiet; one above warns.
      plan_request(req_type'{CH_ENC_LAG, ENC_LAG_LIMIT, 32'd0, 32'd1004, 1'b0}, 1, 0, '0);
      plan_request(req_type'{CH_ENC_LAG, ENC_LAG_LIMIT + 32'd1, 32'd0, 32'd1004, 1'b0},
                   1, 1, rsp_type'{LVL_WARNING, SRC_ENCODER, CH_ENC_LAG,
                                   ENC_LAG_LIMIT + 32'd1, 32'd1004});
      plan_request(req_type'{CH_RENDER_LAG, RENDER_LAG_LIMIT + 32'd1, 32'd0, 32'd1005, 1'b0},
                   1, 0, '0);
      // Exactly one window later the suppression lifts.
      plan_request(req_type'{CH_RENDER_LAG, '1, 32'd0, 32'd1304, 1'b0}, 1, 1,
                   rsp_type'{LVL_WARNING, SRC_ENCODER, CH_RENDER_LAG, '1, 32'd1304});
      // Unused channel code: ignored, but the end-of-sample clear still runs.
      plan_request(req_type'{3'd7, '1, '1, 32'd1304, 1'b1}, 1, 0, '0);
      // Time going backward wraps to a huge elapsed time: not suppressed.
      plan_request(req_type'{CH_RTT, 32'd5, 32'd0, 32'd999, 1'b0}, 1, 1,
                   rsp_type'{LVL_CRITICAL, SRC_NETWORK, CH_RTT, 32'd5, 32'd999});
      plan_request(req_type'{CH_GPU, 32'd0, 32'd0, 32'd0, 1'b1}, 1, 0, '0);

      // Nonzero limits with a hold count of two.
      plan_setting(setting_b);
      plan_request(req_type'{CH_RTT, 32'h0096_0000, 32'd0, 32'd5000, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_RTT, 32'h00FA_0000, 32'd0, 32'd5001, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_RTT, 32'h0032_0000, 32'd0, 32'd5002, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_CPU, 32'h0014_0000, 32'd0, 32'd5003, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_CPU, 32'h0005_0000, 32'd0, 32'd5004, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_FRAME_DROP, 32'd1, 32'd15, 32'd5005, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_FRAME_DROP, 32'd2, 32'd15, 32'd5006, 1'b0}, 0, 0, '0);
      plan_request(req_type'{CH_FRAME_DROP, '1, '1, 32'd5007, 1'b1}, 0, 0, '0);
      plan_request(req_type'{CH_LOSS, '1, 32'd0, 32'd5400, 1'b0}, 0, 0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed plan.
      foreach (plan[i]) begin
         if (plan[i].is_setting) begin
            apply_setting(plan[i].setting);
         end else begin
            send_req(plan[i].req, plan[i].typed, plan[i].typed_hit, plan[i].typed_alert);
         end
      end

      run_phase(IDLE_NONE, PHASE_ITEMS, random_setting());
      run_phase(IDLE_SENDER, PHASE_ITEMS, random_setting());
      run_phase(IDLE_RECEIVER, PHASE_ITEMS, random_setting());
      run_phase(IDLE_BOTH, PHASE_ITEMS, random_setting());
      run_phase(IDLE_BOTH, PHASE_ITEMS / 2, all_ones);

      // Back-pressure: every request alerts while the result side holds off,
      // so the pipeline fills and stalls the request side.
      apply_setting(all_zero);
      pace          = IDLE_NONE;
      stall_request = 400;
      repeat (60) begin
         sim_seconds = sim_seconds + 32'd300;
         r = req_type'{3'($urandom_range(0, 3)), $urandom() | 32'd1, $urandom(),
                       sim_seconds, 1'b0};
         send_req(r, 1'b0, 1'b0, '0);
      end

      settle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule
